>>> sv/dvru_pkg.sv
// Shared types and constants of the distance-vector route update unit.
package dvru_pkg;

  localparam int DEPTH_DEFAULT  = 64;
  localparam logic [7:0] INFINITY_RESET = 8'd16;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SEED  = 2'd1,
    CMD_MERGE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_CLEARED  = 3'd0,
    STAT_INSERTED = 3'd1,
    STAT_IMPROVED = 3'd2,
    STAT_KEPT     = 3'd3,
    STAT_DROPPED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SEARCH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [31:0] dest;
    logic [31:0] next_hop;
    logic [31:0] iface;
    logic [7:0]  cost;
  } route_t;

endpackage

>>> sv/distance_vector_route_update_unit.sv
// Top level of the distance-vector route update unit.
//
//  channel | signals                                   | dir | word
//  --------+-------------------------------------------+-----+-------------------------
//  cfg     | cfg_valid, cfg_ready, cfg_data            | in  | infinity metric
//  in      | in_valid, in_ready, command .. iface addr | in  | clear / seed / merge
//  out     | out_valid, out_ready, status .. iface     | out | outcome and slot contents
//
// Clear, seed and the unused command go from dispatch to finish, and the result is
// registered there once the output is free; a merge searches the stored routes between:
// the route memory gives one entry a cycle on its single read port and the compare works
// on the registered read data. Words are handled one at a time; a new word is taken while
// the last result waits. Reset clears the route count, not the memory: no clearing pass.
module distance_vector_route_update_unit #(
  parameter int TABLE_DEPTH = dvru_pkg::DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] dest_addr,
  input  logic [7:0]  adv_cost,
  input  logic [31:0] neighbor_addr,
  input  logic [31:0] local_iface_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [5:0]  entry_index,
  output logic [6:0]  entry_count,
  output logic [7:0]  stored_cost,
  output logic [31:0] stored_next_hop,
  output logic [31:0] stored_iface
);
  import dvru_pkg::*;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic             rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  route_t           rd_data, wr_data;

  dvru_ctrl #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .command          (command),
    .dest_addr        (dest_addr),
    .adv_cost         (adv_cost),
    .neighbor_addr    (neighbor_addr),
    .local_iface_addr (local_iface_addr),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .entry_index      (entry_index),
    .entry_count      (entry_count),
    .stored_cost      (stored_cost),
    .stored_next_hop  (stored_next_hop),
    .stored_iface     (stored_iface),
    .rd_en            (rd_en),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data)
  );

  dvru_route_mem #(
    .DEPTH (TABLE_DEPTH),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

endmodule

>>> sv/dvru_route_mem.sv
// Route table memory: one write port and one registered read port.
module dvru_route_mem #(
  parameter int DEPTH = dvru_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_addr,
  output dvru_pkg::route_t     rd_data,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_addr,
  input  dvru_pkg::route_t     wr_data
);
  import dvru_pkg::*;

  route_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> sv/dvru_ctrl.sv
// Command sequencer: decodes a word, scans the table and writes back the route.
module dvru_ctrl #(
  parameter int DEPTH = dvru_pkg::DEPTH_DEFAULT,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           command,
  input  logic [31:0]          dest_addr,
  input  logic [7:0]           adv_cost,
  input  logic [31:0]          neighbor_addr,
  input  logic [31:0]          local_iface_addr,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           status,
  output logic [5:0]           entry_index,
  output logic [6:0]           entry_count,
  output logic [7:0]           stored_cost,
  output logic [31:0]          stored_next_hop,
  output logic [31:0]          stored_iface,
  output logic                 rd_en,
  output logic [IDX_W-1:0]     rd_addr,
  input  dvru_pkg::route_t     rd_data,
  output logic                 wr_en,
  output logic [IDX_W-1:0]     wr_addr,
  output dvru_pkg::route_t     wr_data
);
  import dvru_pkg::*;

  state_t             state, state_next;
  logic [7:0]         infinity_metric;
  cmd_t               cmd_q;
  logic [31:0]        dst_q, hop_q, ifc_q;
  logic [7:0]         cost_q;
  logic [CNT_W-1:0]   count, count_next;
  logic [CNT_W-1:0]   scan_idx, scan_next;
  logic               pend, pend_next;
  logic [IDX_W-1:0]   pend_idx;
  logic               res_load;
  status_t            res_status, res_status_next;
  logic [IDX_W-1:0]   res_slot, res_slot_next;
  route_t             res_route, res_route_next;
  logic               full, scan_active, match, out_free;
  logic [8:0]         cost_inc;
  route_t             append_route;

  assign cfg_ready   = 1'b1;
  assign full        = (count == CNT_W'(DEPTH));
  assign scan_active = (scan_idx < count);
  assign match       = pend && (rd_data.dest == dst_q);
  assign out_free    = !out_valid || out_ready;
  assign cost_inc    = {1'b0, adv_cost} + 9'd1;

  // A seed route points at itself; a merged route keeps the advertiser's hop.
  always_comb begin
    if (cmd_q == CMD_SEED) begin
      append_route = '{dest: dst_q, next_hop: dst_q, iface: dst_q, cost: 8'd0};
    end else begin
      append_route = '{dest: dst_q, next_hop: hop_q, iface: ifc_q, cost: cost_q};
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: state_next = (cmd_q == CMD_MERGE) ? ST_SEARCH : ST_FINISH;
      ST_SEARCH:   if (match || (!pend && !scan_active)) state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = (state == ST_IDLE);
    rd_en           = 1'b0;
    rd_addr         = scan_idx[IDX_W-1:0];
    wr_en           = 1'b0;
    wr_addr         = count[IDX_W-1:0];
    wr_data         = append_route;
    count_next      = count;
    scan_next       = scan_idx;
    pend_next       = 1'b0;
    res_load        = 1'b0;
    res_status_next = STAT_KEPT;
    res_slot_next   = '0;
    res_route_next  = '0;
    unique case (state)
      ST_IDLE: begin
      end
      ST_DISPATCH: begin
        scan_next = '0;
        unique case (cmd_q)
          CMD_CLEAR: begin
            count_next      = '0;
            res_load        = 1'b1;
            res_status_next = STAT_CLEARED;
          end
          CMD_SEED: begin
            res_load = 1'b1;
            if (full) begin
              res_status_next = STAT_DROPPED;
            end else begin
              wr_en           = 1'b1;
              count_next      = count + CNT_W'(1);
              res_status_next = STAT_INSERTED;
              res_slot_next   = count[IDX_W-1:0];
              res_route_next  = append_route;
            end
          end
          CMD_MERGE: begin
          end
          CMD_NOP: begin
            res_load        = 1'b1;
            res_status_next = STAT_KEPT;
          end
          default: begin
          end
        endcase
      end
      ST_SEARCH: begin
        // Each read runs one entry ahead of the compare; the first hit wins.
        if (scan_active) begin
          rd_en     = 1'b1;
          scan_next = scan_idx + CNT_W'(1);
          pend_next = 1'b1;
        end
        if (match) begin
          res_load      = 1'b1;
          res_slot_next = pend_idx;
          if (cost_q < rd_data.cost) begin
            wr_en           = 1'b1;
            wr_addr         = pend_idx;
            wr_data         = '{dest: dst_q, next_hop: hop_q, iface: ifc_q, cost: cost_q};
            res_status_next = STAT_IMPROVED;
            res_route_next  = '{dest: dst_q, next_hop: hop_q, iface: ifc_q, cost: cost_q};
          end else begin
            res_status_next = STAT_KEPT;
            res_route_next  = rd_data;
          end
        end else if (!pend && !scan_active) begin
          res_load = 1'b1;
          if (full) begin
            res_status_next = STAT_DROPPED;
          end else begin
            wr_en           = 1'b1;
            count_next      = count + CNT_W'(1);
            res_status_next = STAT_INSERTED;
            res_slot_next   = count[IDX_W-1:0];
            res_route_next  = append_route;
          end
        end
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      infinity_metric <= INFINITY_RESET;
      count           <= '0;
      scan_idx        <= '0;
      pend            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      scan_idx <= scan_next;
      pend     <= pend_next;
      if (cfg_valid && cfg_ready) begin
        infinity_metric <= cfg_data;
      end
      if (state == ST_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_q  <= cmd_t'(command);
      dst_q  <= dest_addr;
      hop_q  <= neighbor_addr;
      ifc_q  <= local_iface_addr;
      cost_q <= (cost_inc > {1'b0, infinity_metric}) ? infinity_metric : cost_inc[7:0];
    end
    if (rd_en) begin
      pend_idx <= scan_idx[IDX_W-1:0];
    end
    if (res_load) begin
      res_status <= res_status_next;
      res_slot   <= res_slot_next;
      res_route  <= res_route_next;
    end
    if (state == ST_FINISH && out_free) begin
      status          <= res_status;
      entry_index     <= 6'(32'(res_slot));
      entry_count     <= 7'(32'(count));
      stored_cost     <= res_route.cost;
      stored_next_hop <= res_route.next_hop;
      stored_iface    <= res_route.iface;
    end
  end

endmodule

>>> sv/dvru_checker.sv
// Port-level checks of the route update unit and the bind that attaches them.
module dvru_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  status,
  input logic [5:0]  entry_index,
  input logic [6:0]  entry_count,
  input logic [7:0]  stored_cost,
  input logic [31:0] stored_next_hop,
  input logic [31:0] stored_iface
);
  import dvru_pkg::*;

  // A waiting result must hold until it is taken.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_index)
      && $stable(entry_count) && $stable(stored_cost))
    else $error("result word changed while stalled");

  // The engine works on one word at a time.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second word taken while one is in progress");

  // A clear leaves an empty table and reports no slot.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_CLEARED |-> entry_count == 7'd0 && entry_index == 6'd0
      && stored_cost == 8'd0 && stored_next_hop == 32'd0 && stored_iface == 32'd0)
    else $error("clear result carries table contents");

  // A dropped append reports no slot contents.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_DROPPED |-> entry_index == 6'd0 && stored_cost == 8'd0
      && stored_next_hop == 32'd0 && stored_iface == 32'd0)
    else $error("dropped result carries slot contents");

  // A route that was just written lies below the route count.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STAT_INSERTED || status == STAT_IMPROVED) |->
      {1'b0, entry_index} < entry_count)
    else $error("written slot lies outside the table");

endmodule

bind distance_vector_route_update_unit dvru_checker u_dvru_checker (.*);
